@@ sv/sc_pkg.sv @@
// Shared constants, types and codes of the sigma-clipped mean block.
`timescale 1ns / 1ps
package sc_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int OFS_W       = 24;
    localparam int RF_W        = 12;
    localparam int PASS_W      = 3;
    localparam int WIDE_W      = 64;
    localparam int STEP_W      = 7;

    localparam logic [PASS_W-1:0] PASSES_MAX = 3'd4;
    localparam logic [RF_W-1:0]   RF_RESET   = 12'd512;
    localparam logic [PASS_W-1:0] PASS_RESET = 3'd2;

    localparam logic CFG_REJECT_FACTOR = 1'b0;
    localparam logic CFG_PASSES        = 1'b1;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } sc_op_t;

    typedef struct packed {
        logic   start;
        sc_op_t op;
    } sc_req_t;

    typedef enum logic {
        RET_CLIP,
        RET_FINAL
    } sc_ret_t;

    typedef enum logic {
        GATHER_FIRST,
        GATHER_SECOND
    } sc_gather_t;

    typedef enum logic [4:0] {
        S_LOAD,
        S_PASS,
        S_GADDR,
        S_GREAD,
        S_GACC,
        S_GEND,
        S_DMUL1,
        S_DMUL1W,
        S_DMUL2,
        S_DMUL2W,
        S_DCHK,
        S_DDIVW,
        S_DSQRT,
        S_DSQRTW,
        S_DEND,
        S_LIM1,
        S_LIM2,
        S_RADDR,
        S_RREAD,
        S_RCMP,
        S_MEAN,
        S_MEANW,
        S_PEND,
        S_OUTW
    } sc_state_t;

endpackage

@@ sv/sc_mdu.sv @@
// Shared iterative multiply, divide and square-root unit, one step per cycle.
`timescale 1ns / 1ps
module sc_mdu (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sc_pkg::sc_req_t              req,
    input  logic [sc_pkg::WIDE_W-1:0]    a,
    input  logic [sc_pkg::WIDE_W-1:0]    b,
    output logic                         done,
    output logic [sc_pkg::WIDE_W-1:0]    res
);
    import sc_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    sc_op_t             op_reg, op_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [WIDE_W-1:0]  p_reg, p_next;
    logic [WIDE_W-1:0]  q_reg, q_next;
    logic [WIDE_W-1:0]  d_reg, d_next;
    logic [WIDE_W:0]    trial;
    logic [WIDE_W:0]    rb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
            op_reg    <= OP_MUL;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        q_reg <= q_next;
        d_reg <= d_next;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        steps_next = steps_reg;
        op_next    = op_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        d_next     = d_reg;
        trial      = {p_reg, q_reg[WIDE_W-1]};
        rb         = {1'b0, q_reg} + {1'b0, d_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            unique case (req.op)
                OP_MUL:
                begin
                    p_next     = '0;
                    q_next     = a;
                    d_next     = b;
                    steps_next = STEP_W'(WIDE_W);
                end
                OP_DIV:
                begin
                    p_next     = '0;
                    q_next     = a;
                    d_next     = b;
                    steps_next = STEP_W'(WIDE_W);
                end
                OP_SQRT:
                begin
                    p_next     = a;
                    q_next     = '0;
                    d_next     = {2'b01, {(WIDE_W-2){1'b0}}};
                    steps_next = STEP_W'(WIDE_W / 2);
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (d_reg[0])
                        p_next = p_reg + q_reg;
                    q_next = {q_reg[WIDE_W-2:0], 1'b0};
                    d_next = {1'b0, d_reg[WIDE_W-1:1]};
                end
                OP_DIV:
                begin
                    if (trial >= {1'b0, d_reg})
                    begin
                        p_next = WIDE_W'(trial - {1'b0, d_reg});
                        q_next = {q_reg[WIDE_W-2:0], 1'b1};
                    end
                    else
                    begin
                        p_next = trial[WIDE_W-1:0];
                        q_next = {q_reg[WIDE_W-2:0], 1'b0};
                    end
                end
                OP_SQRT:
                begin
                    if ({1'b0, p_reg} >= rb)
                    begin
                        p_next = WIDE_W'({1'b0, p_reg} - rb);
                        q_next = {1'b0, q_reg[WIDE_W-1:1]} + d_reg;
                    end
                    else
                    begin
                        q_next = {1'b0, q_reg[WIDE_W-1:1]};
                    end
                    d_next = {2'b00, d_reg[WIDE_W-1:2]};
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            steps_next = steps_reg - 1'b1;
            if (steps_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign res  = (op_reg == OP_MUL) ? p_reg : q_reg;

endmodule

@@ sv/sigma_clipped_mean.sv @@
// Top level of the sigma-clipped mean: sample store, pass sequencer and result register.
//
// Input words (offset, rejected_in, last) load one per cycle into a 64-entry
// sample store while in_stall is low. The word with last set closes the set:
// in_stall then rises and the clipping passes run over the stored samples.
// Each pass walks the store (address, read, accumulate per sample) for the sums,
// runs the shared multiply/divide/root unit (64 + 64 + 64 + 32 steps) for sigma,
// walks the store again (address, read, compare per sample) for the rejection
// test, sums again, and runs sigma and a mean divide. One result word per set.
// The result word waits in its own register under out_stall; the next set
// may load meanwhile, and only its result handover waits while the old word is held.
// Samples beyond 64 are dropped. Configuration (cfg_write, cfg_index, cfg_data) is
// for the user to write only while idle; the block does not enforce it. Reset clears
// the sample count, reject factor to 2.0 and passes to 2; no result is then pending.
`timescale 1ns / 1ps
module sigma_clipped_mean (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic                               cfg_index,
    input  logic [sc_pkg::RF_W-1:0]            cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [sc_pkg::OFS_W-1:0]    offset,
    input  logic                               rejected_in,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [sc_pkg::OFS_W-1:0]    mean,
    output logic [sc_pkg::OFS_W-1:0]           sigma,
    output logic [sc_pkg::CNT_W-1:0]           kept_count,
    output logic [sc_pkg::MAX_SAMPLES-1:0]     rejected_mask,
    output logic                               enough_points
);
    import sc_pkg::*;

    logic signed [OFS_W-1:0] mem [MAX_SAMPLES];
    logic signed [OFS_W-1:0] rdata_reg;
    logic                    mem_we;

    sc_state_t               state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [MAX_SAMPLES-1:0]  flags_reg, flags_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        np_reg, np_next;
    logic signed [30:0]      vsum_reg, vsum_next;
    logic [53:0]             ssum_reg, ssum_next;
    logic signed [OFS_W-1:0] x_reg, x_next;
    logic [46:0]             sq_reg, sq_next;
    sc_gather_t              gret_reg, gret_next;
    sc_ret_t                 dret_reg, dret_next;
    logic [PASS_W-1:0]       pass_reg, pass_next;
    logic [RF_W-1:0]         rf_reg;
    logic [PASS_W-1:0]       passes_reg;
    logic [WIDE_W-1:0]       nss_reg, nss_next;
    logic [WIDE_W-1:0]       s1sq_reg, s1sq_next;
    logic [OFS_W-1:0]        sig_reg, sig_next;
    logic [OFS_W-1:0]        sigma_reg, sigma_next;
    logic [30:0]             lim1_reg, lim1_next;
    logic [42:0]             limit_reg, limit_next;
    logic signed [31:0]      prod_reg, prod_next;
    logic signed [OFS_W-1:0] mean_reg, mean_next;
    logic [CNT_W-1:0]        kept_reg, kept_next;
    logic                    enough_reg, enough_next;
    logic                    ovalid_reg, ovalid_next;
    logic signed [OFS_W-1:0] omean_reg, omean_next;
    logic [OFS_W-1:0]        osigma_reg, osigma_next;
    logic [CNT_W-1:0]        okept_reg, okept_next;
    logic [MAX_SAMPLES-1:0]  omask_reg, omask_next;
    logic                    oenough_reg, oenough_next;

    sc_req_t                 mdu_req;
    logic [WIDE_W-1:0]       mdu_a, mdu_b, mdu_res;
    logic                    mdu_done;

    logic                    in_acc;
    logic [30:0]             s1abs;
    logic signed [47:0]      sq_full;
    logic signed [32:0]      delta;
    logic [32:0]             delta_abs;
    logic [13:0]             den;
    logic [PASS_W-1:0]       npass;

    sc_mdu u_mdu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mdu_req),
        .a     (mdu_a),
        .b     (mdu_b),
        .done  (mdu_done),
        .res   (mdu_res)
    );

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_LOAD);
    assign mem_we   = in_acc && (count_reg < CNT_W'(MAX_SAMPLES));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[IDX_W-1:0]] <= offset;
        rdata_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg     <= RF_RESET;
            passes_reg <= PASS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_REJECT_FACTOR: rf_reg     <= cfg_data;
                CFG_PASSES:        passes_reg <= cfg_data[PASS_W-1:0];
                default:           rf_reg     <= rf_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            count_reg  <= '0;
            sigma_reg  <= '0;
            vsum_reg   <= '0;
            ssum_reg   <= '0;
            ovalid_reg <= 1'b0;
            gret_reg   <= GATHER_FIRST;
            dret_reg   <= RET_CLIP;
            pass_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sigma_reg  <= sigma_next;
            vsum_reg   <= vsum_next;
            ssum_reg   <= ssum_next;
            ovalid_reg <= ovalid_next;
            gret_reg   <= gret_next;
            dret_reg   <= dret_next;
            pass_reg   <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg   <= flags_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        np_reg      <= np_next;
        x_reg       <= x_next;
        sq_reg      <= sq_next;
        nss_reg     <= nss_next;
        s1sq_reg    <= s1sq_next;
        sig_reg     <= sig_next;
        lim1_reg    <= lim1_next;
        limit_reg   <= limit_next;
        prod_reg    <= prod_next;
        mean_reg    <= mean_next;
        kept_reg    <= kept_next;
        enough_reg  <= enough_next;
        omean_reg   <= omean_next;
        osigma_reg  <= osigma_next;
        okept_reg   <= okept_next;
        omask_reg   <= omask_next;
        oenough_reg <= oenough_next;
    end

    assign s1abs   = vsum_reg[30] ? 31'(-vsum_reg) : 31'(vsum_reg);
    assign sq_full = 48'(rdata_reg) * 48'(rdata_reg);
    assign delta   = 33'(prod_reg) - 33'(vsum_reg);
    assign delta_abs = delta[32] ? 33'(-delta) : 33'(delta);
    assign den     = 14'(n_reg) * 14'(n_reg - 1'b1);
    assign npass   = (passes_reg == '0) ? PASS_W'(1) :
                     ((passes_reg > PASSES_MAX) ? PASSES_MAX : passes_reg);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        flags_next   = flags_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        np_next      = np_reg;
        vsum_next    = vsum_reg;
        ssum_next    = ssum_reg;
        x_next       = x_reg;
        sq_next      = sq_reg;
        gret_next    = gret_reg;
        dret_next    = dret_reg;
        pass_next    = pass_reg;
        nss_next     = nss_reg;
        s1sq_next    = s1sq_reg;
        sig_next     = sig_reg;
        sigma_next   = sigma_reg;
        lim1_next    = lim1_reg;
        limit_next   = limit_reg;
        prod_next    = prod_reg;
        mean_next    = mean_reg;
        kept_next    = kept_reg;
        enough_next  = enough_reg;
        ovalid_next  = ovalid_reg && out_stall;
        omean_next   = omean_reg;
        osigma_next  = osigma_reg;
        okept_next   = okept_reg;
        omask_next   = omask_reg;
        oenough_next = oenough_reg;
        mdu_req      = '{start: 1'b0, op: OP_MUL};
        mdu_a        = '0;
        mdu_b        = '0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (count_reg == '0)
                        flags_next = '0;
                    if (count_reg < CNT_W'(MAX_SAMPLES))
                    begin
                        flags_next[count_reg[IDX_W-1:0]] = rejected_in;
                        count_next = count_reg + 1'b1;
                    end
                    if (last)
                    begin
                        sigma_next = '0;
                        pass_next  = npass;
                        gret_next  = GATHER_FIRST;
                        state_next = S_PASS;
                    end
                end
            end
            S_PASS:
            begin
                idx_next   = '0;
                n_next     = '0;
                vsum_next  = '0;
                ssum_next  = '0;
                state_next = S_GADDR;
            end
            S_GADDR:
            begin
                state_next = S_GREAD;
            end
            S_GREAD:
            begin
                x_next     = rdata_reg;
                sq_next    = sq_full[46:0];
                state_next = S_GACC;
            end
            S_GACC:
            begin
                if (!flags_reg[idx_reg[IDX_W-1:0]])
                begin
                    vsum_next = vsum_reg + 31'(x_reg);
                    ssum_next = ssum_reg + 54'(sq_reg);
                    n_next    = n_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == count_reg)
                    state_next = S_GEND;
                else
                    state_next = S_GADDR;
            end
            S_GEND:
            begin
                if (gret_reg == GATHER_FIRST)
                begin
                    np_next = n_reg;
                    if (n_reg < CNT_W'(2))
                    begin
                        mean_next   = '0;
                        kept_next   = n_reg;
                        enough_next = 1'b0;
                        state_next  = S_PEND;
                    end
                    else
                    begin
                        dret_next  = RET_CLIP;
                        state_next = S_DMUL1;
                    end
                end
                else
                begin
                    kept_next   = n_reg;
                    enough_next = 1'b1;
                    if (n_reg >= CNT_W'(2))
                    begin
                        dret_next  = RET_FINAL;
                        state_next = S_DMUL1;
                    end
                    else
                    begin
                        sigma_next = '0;
                        state_next = S_MEAN;
                    end
                end
            end
            S_DMUL1:
            begin
                mdu_req    = '{start: 1'b1, op: OP_MUL};
                mdu_a      = WIDE_W'(n_reg);
                mdu_b      = WIDE_W'(ssum_reg);
                state_next = S_DMUL1W;
            end
            S_DMUL1W:
            begin
                if (mdu_done)
                begin
                    nss_next   = mdu_res;
                    state_next = S_DMUL2;
                end
            end
            S_DMUL2:
            begin
                mdu_req    = '{start: 1'b1, op: OP_MUL};
                mdu_a      = WIDE_W'(s1abs);
                mdu_b      = WIDE_W'(s1abs);
                state_next = S_DMUL2W;
            end
            S_DMUL2W:
            begin
                if (mdu_done)
                begin
                    s1sq_next  = mdu_res;
                    state_next = S_DCHK;
                end
            end
            S_DCHK:
            begin
                if (nss_reg <= s1sq_reg)
                begin
                    sig_next   = '0;
                    state_next = S_DEND;
                end
                else
                begin
                    mdu_req    = '{start: 1'b1, op: OP_DIV};
                    mdu_a      = nss_reg - s1sq_reg;
                    mdu_b      = WIDE_W'(den);
                    state_next = S_DDIVW;
                end
            end
            S_DDIVW:
            begin
                if (mdu_done)
                begin
                    nss_next   = mdu_res;
                    state_next = S_DSQRT;
                end
            end
            S_DSQRT:
            begin
                mdu_req    = '{start: 1'b1, op: OP_SQRT};
                mdu_a      = nss_reg;
                state_next = S_DSQRTW;
            end
            S_DSQRTW:
            begin
                if (mdu_done)
                begin
                    if (mdu_res[WIDE_W-1:OFS_W] != '0)
                        sig_next = '1;
                    else
                        sig_next = mdu_res[OFS_W-1:0];
                    state_next = S_DEND;
                end
            end
            S_DEND:
            begin
                if (dret_reg == RET_CLIP)
                    state_next = S_LIM1;
                else
                begin
                    sigma_next = sig_reg;
                    state_next = S_MEAN;
                end
            end
            S_LIM1:
            begin
                lim1_next  = 31'(np_reg) * 31'(sig_reg);
                state_next = S_LIM2;
            end
            S_LIM2:
            begin
                limit_next = 43'(lim1_reg) * 43'(rf_reg);
                idx_next   = '0;
                state_next = S_RADDR;
            end
            S_RADDR:
            begin
                state_next = S_RREAD;
            end
            S_RREAD:
            begin
                prod_next  = 32'($signed({1'b0, np_reg})) * 32'(rdata_reg);
                state_next = S_RCMP;
            end
            S_RCMP:
            begin
                if (43'({delta_abs[31:0], 8'h00}) > limit_reg)
                    flags_next[idx_reg[IDX_W-1:0]] = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == count_reg)
                begin
                    gret_next  = GATHER_SECOND;
                    state_next = S_PASS;
                end
                else
                    state_next = S_RADDR;
            end
            S_MEAN:
            begin
                if (n_reg == '0)
                begin
                    mean_next  = '0;
                    state_next = S_PEND;
                end
                else
                begin
                    mdu_req    = '{start: 1'b1, op: OP_DIV};
                    mdu_a      = WIDE_W'({s1abs, 1'b0}) + WIDE_W'(n_reg);
                    mdu_b      = WIDE_W'({n_reg, 1'b0});
                    state_next = S_MEANW;
                end
            end
            S_MEANW:
            begin
                if (mdu_done)
                begin
                    if (vsum_reg[30])
                        mean_next = -$signed(mdu_res[OFS_W-1:0]);
                    else
                        mean_next = $signed(mdu_res[OFS_W-1:0]);
                    state_next = S_PEND;
                end
            end
            S_PEND:
            begin
                pass_next = pass_reg - 1'b1;
                if (pass_reg > PASS_W'(1))
                begin
                    gret_next  = GATHER_FIRST;
                    state_next = S_PASS;
                end
                else
                    state_next = S_OUTW;
            end
            S_OUTW:
            begin
                if (!ovalid_reg)
                begin
                    ovalid_next  = 1'b1;
                    omean_next   = mean_reg;
                    osigma_next  = sigma_reg;
                    okept_next   = kept_reg;
                    omask_next   = flags_reg;
                    oenough_next = enough_reg;
                    count_next   = '0;
                    state_next   = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    assign out_valid     = ovalid_reg;
    assign mean          = omean_reg;
    assign sigma         = osigma_reg;
    assign kept_count    = okept_reg;
    assign rejected_mask = omask_reg;
    assign enough_points = oenough_reg;

endmodule

@@ verif/tb.sv @@
// Testbench for sigma_clipped_mean: directed and random sample sets checked against a clipping predictor.
`timescale 1ns / 1ps
module tb;
    import sc_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [OFS_W-1:0] mean;
        logic [OFS_W-1:0]        sigma;
        logic [CNT_W-1:0]        kept;
        logic [WIDE_W-1:0]       mask;
        logic                    enough;
    } clip_result_t;

    class clip_scoreboard;
        longint       samples[MAX_SAMPLES];
        bit           flags[MAX_SAMPLES];
        int           stored;
        longint       sum1;
        longint       sum2;
        logic [RF_W-1:0]   factor;
        logic [PASS_W-1:0] pass_cfg;
        clip_result_t pending[$];
        int           errors;

        function new();
            stored   = 0;
            factor   = RF_RESET;
            pass_cfg = PASS_RESET;
            errors   = 0;
        endfunction

        function int gather_sums();
            int n;
            n = 0;
            sum1 = 0;
            sum2 = 0;
            for (int i = 0; i < stored; i++)
                if (!flags[i])
                begin
                    sum1 += samples[i];
                    sum2 += samples[i] * samples[i];
                    n++;
                end
            return n;
        endfunction

        function logic [OFS_W-1:0] std_dev(int n);
            longint      num;
            logic [63:0] v, r, b;
            num = longint'(n) * sum2 - sum1 * sum1;
            if (num <= 0)
                return 0;
            v = 64'(num) / 64'(n * (n - 1));
            r = 0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[OFS_W-1:0];
        endfunction

        function longint round_mean(int n);
            longint m, q;
            if (n == 0)
                return 0;
            m = (sum1 < 0) ? -sum1 : sum1;
            q = (2 * m + n) / (2 * n);
            return (sum1 < 0) ? -q : q;
        endfunction

        function void note_word(logic signed [OFS_W-1:0] ofs, bit rej, bit lst);
            int           npass, n, kept;
            logic [OFS_W-1:0] sig_run, sig;
            longint       mean_v, lim, d;
            clip_result_t res;
            if (stored < MAX_SAMPLES)
            begin
                samples[stored] = ofs;
                flags[stored]   = rej;
                stored++;
            end
            if (!lst)
                return;
            npass = (pass_cfg == 0) ? 1 : ((pass_cfg > PASSES_MAX) ? PASSES_MAX : pass_cfg);
            sig_run = 0;
            mean_v = 0;
            kept = 0;
            res.enough = 0;
            for (int p = 0; p < npass; p++)
            begin
                n = gather_sums();
                if (n < 2)
                begin
                    mean_v = 0;
                    kept = n;
                    res.enough = 0;
                    continue;
                end
                sig = std_dev(n);
                lim = longint'(n) * longint'(sig) * longint'(factor);
                for (int i = 0; i < stored; i++)
                begin
                    d = longint'(n) * samples[i] - sum1;
                    if (d < 0)
                        d = -d;
                    if (d * 256 > lim)
                        flags[i] = 1;
                end
                kept = gather_sums();
                sig_run = (kept >= 2) ? std_dev(kept) : 0;
                mean_v = round_mean(kept);
                res.enough = 1;
            end
            res.mean  = mean_v[OFS_W-1:0];
            res.sigma = sig_run;
            res.kept  = kept[CNT_W-1:0];
            res.mask  = 0;
            for (int i = 0; i < stored; i++)
                res.mask[i] = flags[i];
            pending.push_back(res);
            stored = 0;
        endfunction

        function void check_result(clip_result_t got);
            clip_result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result word: mean %0d", got.mean);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.mean !== want.mean)
            begin
                $error("mean: expected %0d, got %0d", want.mean, got.mean);
                errors++;
            end
            if (got.sigma !== want.sigma)
            begin
                $error("sigma: expected %0d, got %0d", want.sigma, got.sigma);
                errors++;
            end
            if (got.kept !== want.kept)
            begin
                $error("kept_count: expected %0d, got %0d", want.kept, got.kept);
                errors++;
            end
            if (got.mask !== want.mask)
            begin
                $error("rejected_mask: expected %h, got %h", want.mask, got.mask);
                errors++;
            end
            if (got.enough !== want.enough)
            begin
                $error("enough_points: expected %0d, got %0d", want.enough, got.enough);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic                     cfg_index;
    logic [RF_W-1:0]          cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic signed [OFS_W-1:0]  offset;
    logic                     rejected_in;
    logic                     last;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [OFS_W-1:0]  mean;
    logic [OFS_W-1:0]         sigma;
    logic [CNT_W-1:0]         kept_count;
    logic [MAX_SAMPLES-1:0]   rejected_mask;
    logic                     enough_points;

    clip_scoreboard sb;
    int  cycles;
    int  words_sent;
    bit  in_quiet;
    bit  out_quiet;

    sigma_clipped_mean uut (.*);

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic send_word(logic signed [OFS_W-1:0] ofs, bit rej, bit lst);
        int gap;
        gap = in_quiet ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1;
        offset      <= ofs;
        rejected_in <= rej;
        last        <= lst;
        do @(posedge clk); while (in_stall);
        sb.note_word(ofs, rej, lst);
        words_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [RF_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 0;
        if (idx == CFG_REJECT_FACTOR)
            sb.factor = val;
        else
            sb.pass_cfg = val[PASS_W-1:0];
    endtask

    task automatic random_set();
        int size, pick, spread;
        logic signed [OFS_W-1:0] center, v;
        pick = $urandom_range(0, 99);
        size = (pick < 90) ? $urandom_range(1, 20) :
               (pick < 98) ? $urandom_range(21, 64) : $urandom_range(65, 70);
        center = OFS_W'($urandom);
        spread = 1 << $urandom_range(0, 20);
        in_quiet = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < size; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                v = OFS_W'($urandom);
            else
                v = center + OFS_W'($urandom_range(0, 2 * spread)) - OFS_W'(spread);
            send_word(v, $urandom_range(0, 7) == 0, i == size - 1);
        end
    endtask

    initial
    begin
        logic [RF_W-1:0] rf_list[8]   = '{512, 0, 4095, 256, 128, 1024, 384, 700};
        logic [RF_W-1:0] pass_list[8] = '{2, 0, 7, 1, 4, 3, 5, 4};
        sb = new();
        cycles = 0;
        words_sent = 0;
        in_quiet = 0;
        out_quiet = 0;
        rst_n = 0;
        cfg_write = 0;
        cfg_index = CFG_REJECT_FACTOR;
        cfg_data = 0;
        in_valid = 0;
        offset = 0;
        rejected_in = 0;
        last = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        send_word(24'sh7FFFFF, 0, 0);
        send_word(-24'sh800000, 0, 1);
        send_word(24'sh001234, 0, 1);
        send_word(24'sh000100, 1, 0);
        send_word(24'sh000200, 1, 0);
        send_word(24'sh000300, 1, 1);
        for (int i = 0; i < 5; i++)
            send_word(-24'sh004000, 0, i == 4);
        for (int i = 0; i < 8; i++)
            send_word((i == 7) ? 24'sh7FF000 : 24'sh001000 + 24'(i), i == 3, i == 7);
        send_word(24'sh000010, 0, 0);
        send_word(24'sh000010, 1, 1);

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_reg(CFG_REJECT_FACTOR, rf_list[ph]);
                write_reg(CFG_PASSES, (ph == 7) ? RF_W'($urandom) : pass_list[ph]);
            end
            while (words_sent < (ph + 1) * 250)
                random_set();
        end
        drain();
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        int gap;
        clip_result_t got;
        out_stall = 0;
        forever
        begin
            out_quiet = ($urandom_range(0, 4) == 0);
            gap = out_quiet ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                @(negedge clk);
                out_stall <= 1;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall <= 0;
            do @(posedge clk); while (!out_valid);
            got.mean   = mean;
            got.sigma  = sigma;
            got.kept   = kept_count;
            got.mask   = rejected_mask;
            got.enough = enough_points;
            sb.check_result(got);
        end
    end
endmodule
